### sv/afs_pkg.sv
`default_nettype none

package afs_pkg;

   // Largest animation the block is built for; frame counts above it saturate.
   localparam int unsigned MAX_FRAMES = 256;

   localparam int unsigned TIMER_W   = 16;
   localparam int unsigned FRAME_W   = 8;
   localparam int unsigned COUNT_W   = 9;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 16;
   localparam int unsigned REQ_DAT_W = 8;
   localparam int unsigned RSP_DAT_W = 16;

   // Upper bound on the effective frame count: the smaller of 256 and MAX_FRAMES.
   localparam int unsigned COUNT_CAP_INT = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;
   localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(COUNT_CAP_INT);

   typedef enum logic [1:0] {
      MODE_FINISH   = 2'd0,
      MODE_STATIC   = 2'd1,
      MODE_LOOP     = 2'd2,
      MODE_PINGPONG = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE  = 2'd0,
      CSR_TICKS = 2'd1,
      CSR_COUNT = 2'd2
   } csr_index_type;

   typedef struct packed {
      mode_type             mode;
      logic [TIMER_W-1:0]   ticks_per_frame;
      logic [COUNT_W-1:0]   frame_count;
   } cfg_type;

   typedef struct packed {
      logic [TIMER_W-1:0]   tick_timer;
      logic [FRAME_W-1:0]   current_frame;
      logic                 going_back;
   } seq_state_type;

endpackage

`default_nettype wire

### sv/animation_frame_sequencer.sv
`default_nettype none

// Prescaled frame counter for one animation. Each item on the req channel is
// one tick whose enable_flag is req_tdata[0]; each tick yields exactly one
// result item with frame_number, draw_now and running. An item passes an input
// register and then a result register, and is offered on rsp once the result
// register has taken it; one item is taken every cycle while the result side
// keeps up, and the combinational state update (timer compare, frame step, mode
// mux) sets that rate. Registers on the csr port: 0 mode, 1 ticks_per_frame,
// 2 frame_count; write them only while no tick is in flight.
module animation_frame_sequencer
   import afs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Tick items.
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [REQ_DAT_W-1:0] req_tdata,  // [0] enable_flag, rest zero
   // Result items.
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [RSP_DAT_W-1:0]      rsp_tdata,  // [7:0] frame_number, [8] draw_now,
                                                 // [9] running, rest zero
   // Register writes.
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data
);

   cfg_type       cfg;
   seq_state_type state_ff, state_in, state_step;
   logic          in_valid_ff, in_valid_in;
   logic          flag_ff, flag_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic          rsp_draw_ff, rsp_draw_in;
   logic          rsp_run_ff, rsp_run_in;
   logic          step_draw, step_run;
   logic          rsp_free;
   logic          advance;

   assign csr_ready = 1'b1;

   afs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   afs_step u_step (
      .cfg         (cfg),
      .enable_flag (flag_ff),
      .cur         (state_ff),
      .nxt         (state_step),
      .draw_now    (step_draw),
      .running     (step_run)
   );

   // Flow control: the input stage moves on when the result register is free.
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && rsp_free;
   assign req_tready = !in_valid_ff || rsp_free;

   // Input stage.
   always_comb begin
      in_valid_in = in_valid_ff;
      flag_in     = flag_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         flag_in     = req_tdata[0];
      end
   end

   // State update and result register.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_frame_in = rsp_frame_ff;
      rsp_draw_in  = rsp_draw_ff;
      rsp_run_in   = rsp_run_ff;
      if (advance) begin
         state_in     = state_step;
         rsp_valid_in = 1'b1;
         rsp_frame_in = state_step.current_frame;
         rsp_draw_in  = step_draw;
         rsp_run_in   = step_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
      flag_ff      <= flag_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_draw_ff  <= rsp_draw_in;
      rsp_run_ff   <= rsp_run_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DAT_W - FRAME_W - 2)'(0), rsp_run_ff, rsp_draw_ff, rsp_frame_ff};

   // A held tick is never dropped while the result side stalls.
   a_hold_tick: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("tick lost in input stage");

   // Every tick that moves on produces a result.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("tick produced no result");

   // Ping-pong with the flag low clears the whole sequencer state.
   a_pingpong_clear: assert property (@(posedge clock) disable iff (reset)
      advance && cfg.mode == MODE_PINGPONG && !flag_ff |=> state_ff == '0)
      else $error("ping-pong stop did not clear state");

   // Static mode never changes the state.
   a_static_holds: assert property (@(posedge clock) disable iff (reset)
      advance && cfg.mode == MODE_STATIC |=> $stable(state_ff))
      else $error("state changed in static mode");

endmodule

`default_nettype wire

### sv/afs_csr.sv
`default_nettype none

module afs_csr
   import afs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data,
   output cfg_type                   cfg
);

   mode_type           mode_ff, mode_in;
   logic [TIMER_W-1:0] ticks_ff, ticks_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // Decode a register write; unknown indexes leave everything unchanged.
   always_comb begin
      mode_in  = mode_ff;
      ticks_in = ticks_ff;
      count_in = count_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_MODE:  mode_in  = mode_type'(csr_data[1:0]);
            CSR_TICKS: ticks_in = csr_data[TIMER_W-1:0];
            CSR_COUNT: count_in = csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_FINISH;
         ticks_ff <= TIMER_W'(1);
         count_ff <= COUNT_W'(4);
      end else begin
         mode_ff  <= mode_in;
         ticks_ff <= ticks_in;
         count_ff <= count_in;
      end
   end

   assign cfg.mode            = mode_ff;
   assign cfg.ticks_per_frame = ticks_ff;
   assign cfg.frame_count     = count_ff;

endmodule

`default_nettype wire

### sv/afs_step.sv
`default_nettype none

module afs_step
   import afs_pkg::*;
(
   input  wire cfg_type       cfg,
   input  wire logic          enable_flag,
   input  wire seq_state_type cur,
   output seq_state_type      nxt,
   output logic               draw_now,
   output logic               running
);

   logic [COUNT_W-1:0] eff_count;
   logic [FRAME_W-1:0] last_frame;
   logic [TIMER_W-1:0] timer_inc;
   logic               frame_due;
   logic [TIMER_W-1:0] timer_after;
   logic [FRAME_W-1:0] wrap_frame;
   logic [FRAME_W-1:0] bounce_frame;
   logic               bounce_back;

   // Effective frame count: zero reads as one, large values saturate.
   always_comb begin
      eff_count = cfg.frame_count;
      if (eff_count == '0) begin
         eff_count = COUNT_W'(1);
      end
      if (eff_count > COUNT_CAP) begin
         eff_count = COUNT_CAP;
      end
   end

   assign last_frame = FRAME_W'(eff_count - COUNT_W'(1));

   // Prescale timer: a frame is due when timer+1 reaches the period or wraps to 0.
   assign timer_inc   = cur.tick_timer + TIMER_W'(1);
   assign frame_due   = (timer_inc >= cfg.ticks_per_frame) || (timer_inc == '0);
   assign timer_after = frame_due ? '0 : timer_inc;

   // Forward wrap, taken whenever the frame is at or past the last one.
   assign wrap_frame = (cur.current_frame >= last_frame) ? '0
                     : cur.current_frame + FRAME_W'(1);

   // Ping-pong step between the two ends.
   always_comb begin
      bounce_frame = cur.current_frame;
      bounce_back  = cur.going_back;
      if (eff_count == COUNT_W'(1)) begin
         bounce_frame = '0;
         bounce_back  = 1'b0;
      end else if (!cur.going_back) begin
         if (cur.current_frame >= last_frame) begin
            bounce_frame = cur.current_frame - FRAME_W'(1);
            bounce_back  = 1'b1;
         end else begin
            bounce_frame = cur.current_frame + FRAME_W'(1);
         end
      end else begin
         if (cur.current_frame == '0) begin
            bounce_frame = FRAME_W'(1);
            bounce_back  = 1'b0;
         end else begin
            bounce_frame = cur.current_frame - FRAME_W'(1);
         end
      end
   end

   // Mode select for the next state and the two status bits.
   always_comb begin
      nxt      = cur;
      running  = 1'b1;
      draw_now = 1'b0;
      case (cfg.mode)
         MODE_FINISH: begin
            nxt.tick_timer = timer_after;
            if (frame_due) begin
               nxt.current_frame = wrap_frame;
            end
            running  = enable_flag || (nxt.current_frame != '0);
            draw_now = running;
         end
         MODE_STATIC: begin
            draw_now = !enable_flag;
         end
         MODE_LOOP: begin
            if (!enable_flag) begin
               draw_now       = 1'b1;
               nxt.tick_timer = timer_after;
               if (frame_due) begin
                  nxt.current_frame = wrap_frame;
               end
            end
         end
         MODE_PINGPONG: begin
            if (enable_flag) begin
               draw_now       = 1'b1;
               nxt.tick_timer = timer_after;
               if (frame_due) begin
                  nxt.current_frame = bounce_frame;
                  nxt.going_back    = bounce_back;
               end
            end else begin
               running  = 1'b0;
               nxt      = '0;
            end
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

### verif/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import afs_pkg::*;

   // One expected tick result, as carried in rsp_tdata.
   typedef struct {
      logic [FRAME_W-1:0] frame_number;
      logic               draw_now;
      logic               running;
   } frame_result_type;

   // Tracks the sequencer's registers and state, predicts each tick's result
   // and checks the results that come back against it.
   class frame_scoreboard;
      mode_type           mode;
      logic [TIMER_W-1:0] ticks_per_frame;
      logic [COUNT_W-1:0] frame_count;
      logic [TIMER_W-1:0] tick_timer;
      logic [FRAME_W-1:0] current_frame;
      logic               going_back;
      frame_result_type   pending_frames[$];
      int unsigned        errors;
      int unsigned        results_seen;

      function new();
         mode = MODE_FINISH;
         ticks_per_frame = 1;
         frame_count = 4;
         tick_timer = '0;
         current_frame = '0;
         going_back = 1'b0;
         errors = 0;
         results_seen = 0;
      endfunction

      function void write_reg(csr_index_type index, logic [CSR_DAT_W-1:0] value);
         case (index)
            CSR_MODE:  mode = mode_type'(value[1:0]);
            CSR_TICKS: ticks_per_frame = value[TIMER_W-1:0];
            CSR_COUNT: frame_count = value[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      // A count of zero behaves as one; large counts saturate at the cap.
      function int unsigned active_count();
         int unsigned n;
         n = frame_count;
         if (n == 0) n = 1;
         if (n > COUNT_CAP_INT) n = COUNT_CAP_INT;
         return n;
      endfunction

      // Counts one tick of the prescaler and reports whether the frame moves.
      function bit timer_expired();
         logic [TIMER_W-1:0] t;
         t = tick_timer + 1'b1;
         if (t >= ticks_per_frame || t == '0) begin
            tick_timer = '0;
            return 1'b1;
         end
         tick_timer = t;
         return 1'b0;
      endfunction

      // Forward step that wraps to frame zero, also from a frame past the end.
      function void step_forward();
         if (current_frame >= active_count() - 1) current_frame = '0;
         else current_frame = current_frame + 1'b1;
      endfunction

      // Ping-pong step between the first and the last frame.
      function void step_bounce();
         int unsigned n;
         n = active_count();
         if (n == 1) begin
            current_frame = '0;
            going_back = 1'b0;
         end else if (!going_back) begin
            if (current_frame + 1 >= n) begin
               current_frame = current_frame - 1'b1;
               going_back = 1'b1;
            end else begin
               current_frame = current_frame + 1'b1;
            end
         end else if (current_frame == '0) begin
            current_frame = 1;
            going_back = 1'b0;
         end else begin
            current_frame = current_frame - 1'b1;
         end
      endfunction

      // Updates the state for one accepted tick and queues its result.
      function void note_tick(logic flag);
         frame_result_type r;
         r.running = 1'b1;
         r.draw_now = 1'b0;
         case (mode)
            MODE_FINISH: begin
               if (timer_expired()) step_forward();
               r.running = !(!flag && current_frame == '0);
               r.draw_now = r.running;
            end
            MODE_STATIC: begin
               r.draw_now = !flag;
            end
            MODE_LOOP: begin
               if (!flag) begin
                  r.draw_now = 1'b1;
                  if (timer_expired()) step_forward();
               end
            end
            default: begin
               if (flag) begin
                  r.draw_now = 1'b1;
                  if (timer_expired()) step_bounce();
               end else begin
                  r.running = 1'b0;
                  tick_timer = '0;
                  going_back = 1'b0;
                  current_frame = '0;
               end
            end
         endcase
         r.frame_number = current_frame;
         pending_frames.push_back(r);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            errors++;
            $display("%0d ns: %s expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      // Compares one accepted result with the oldest predicted one.
      function void check_result(logic [RSP_DAT_W-1:0] data);
         frame_result_type want;
         results_seen++;
         if (pending_frames.size() == 0) begin
            errors++;
            $display("%0d ns: result %h arrived with no tick outstanding", $time, data);
            return;
         end
         want = pending_frames.pop_front();
         compare_field("frame_number", want.frame_number, data[7:0]);
         compare_field("draw_now", want.draw_now, data[8]);
         compare_field("running", want.running, data[9]);
         compare_field("padding", '0, data[RSP_DAT_W-1:10]);
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [REQ_DAT_W-1:0] req_tdata;   // [0] enable_flag, rest zero
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_DAT_W-1:0] rsp_tdata;   // [7:0] frame_number, [8] draw_now, [9] running
   logic                 csr_valid;
   logic                 csr_ready;
   csr_index_type        csr_index;
   logic [CSR_DAT_W-1:0] csr_data;

   frame_scoreboard scoreboard;
   int sender_idle_pct;
   int stall_pct;
   int holdoff_request;
   int holdoff_left;
   int ticks_sent;
   int writes_done;

   animation_frame_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Observe every handshake at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) scoreboard.write_reg(csr_index, csr_data);
         if (req_tvalid && req_tready) scoreboard.note_tick(req_tdata[0]);
         if (rsp_tvalid && rsp_tready) scoreboard.check_result(rsp_tdata);
      end
   end

   // Result side: random stalls, plus a long hold-off when one is requested.
   always @(negedge clock) begin
      if (holdoff_request != 0) begin
         holdoff_left = holdoff_request;
         holdoff_request = 0;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_tick(input logic flag);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DAT_W'(flag);
      do @(posedge clock); while (!req_tready);
      ticks_sent++;
   endtask

   // Sends n ticks whose flags are taken from the low bits, first tick first.
   task automatic send_flags(input logic [31:0] flags, input int n);
      for (int i = 0; i < n; i++) send_tick(flags[i]);
   endtask

   task automatic run_ticks(input int n, input int high_pct);
      repeat (n) send_tick($urandom_range(99) < high_pct);
   endtask

   // Stops offering ticks until every outstanding result has come back.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (scoreboard.pending_frames.size() != 0) @(negedge clock);
   endtask

   // Register writes happen only once the block has nothing in flight.
   task automatic write_reg(input csr_index_type index, input logic [CSR_DAT_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      writes_done++;
   endtask

   task automatic apply_settings(input mode_type m, input logic [15:0] ticks,
                                 input logic [15:0] count);
      write_reg(CSR_MODE, CSR_DAT_W'(m));
      write_reg(CSR_TICKS, ticks);
      write_reg(CSR_COUNT, count);
   endtask

   task automatic set_idling(input int phase);
      case (phase % 4)
         0: begin sender_idle_pct = 0;  stall_pct = 0;  end
         1: begin sender_idle_pct = 62; stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  stall_pct = 62; end
         default: begin sender_idle_pct = 37; stall_pct = 37; end
      endcase
   endtask

   // Mostly short periods so frames move often; now and then the extremes.
   function automatic logic [15:0] pick_ticks();
      int r;
      r = $urandom_range(99);
      if (r < 55) return $urandom_range(1, 3);
      if (r < 75) return $urandom_range(4, 12);
      if (r < 85) return $urandom_range(13, 300);
      if (r < 92) return 16'd0;
      return 16'hFFFF;
   endfunction

   // Small counts dominate; the cap, a count of one and out-of-range values too.
   function automatic logic [15:0] pick_count();
      int r;
      r = $urandom_range(99);
      if (r < 40) return $urandom_range(2, 6);
      if (r < 60) return $urandom_range(7, 40);
      if (r < 70) return 16'd1;
      if (r < 78) return 16'd256;
      if (r < 85) return $urandom_range(200, 255);
      if (r < 92) return 16'd0;
      return $urandom_range(257, 511);
   endfunction

   initial begin
      int random_ticks;
      int phase;
      int n;
      int high_pct;
      mode_type m;
      logic [15:0] count;

      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = CSR_MODE;
      csr_data = '0;
      rsp_tready = 1'b0;
      sender_idle_pct = 0;
      stall_pct = 0;
      holdoff_request = 0;
      holdoff_left = 0;
      ticks_sent = 0;
      writes_done = 0;
      scoreboard = new();
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Finish cycle with the reset settings: wrap at four, then stop at frame zero.
      send_flags(32'b0000_1111, 8);
      // Static: draw follows the inverted flag.
      write_reg(CSR_MODE, CSR_DAT_W'(MODE_STATIC));
      send_flags(32'b10, 2);
      // Loop: frozen while the flag is high, advancing while it is low.
      write_reg(CSR_MODE, CSR_DAT_W'(MODE_LOOP));
      send_flags(32'b001, 3);
      // Ping-pong over three frames, then a low flag clears everything.
      write_reg(CSR_COUNT, 16'd3);
      write_reg(CSR_MODE, CSR_DAT_W'(MODE_PINGPONG));
      send_flags(32'b01_1111, 6);
      // Ping-pong with a single frame holds frame zero.
      write_reg(CSR_COUNT, 16'd1);
      send_flags(32'b11, 2);
      // A zero count and a zero period behave as one, a huge count saturates.
      apply_settings(MODE_FINISH, 16'd0, 16'd0);
      send_flags(32'b01, 2);
      write_reg(CSR_COUNT, 16'd511);
      send_flags(32'b1, 1);
      // Lowering the period below the running timer forces an advance.
      write_reg(CSR_TICKS, 16'd200);
      send_flags(32'b111, 3);
      write_reg(CSR_TICKS, 16'd2);
      send_flags(32'b1, 1);

      // Long result stall while ticks keep coming, so the input backs up.
      apply_settings(MODE_FINISH, 16'd1, 16'd5);
      set_idling(0);
      @(posedge clock);
      holdoff_request = 40;
      run_ticks(16, 50);
      wait_idle();

      // Random phases; the first climbs to the top frame and leaves it high,
      // the second lowers the count below it.
      random_ticks = 0;
      phase = 0;
      while (random_ticks < 480) begin
         set_idling(phase);
         if (phase == 0) begin
            apply_settings(MODE_PINGPONG, 16'd1, 16'd256);
            n = 300;
            high_pct = 100;
         end else begin
            m = mode_type'($urandom_range(3));
            count = (phase == 1) ? 16'($urandom_range(2, 8)) : pick_count();
            apply_settings(m, pick_ticks(), count);
            n = $urandom_range(20, 60);
            case ($urandom_range(4))
               0: high_pct = 0;
               1: high_pct = 20;
               2: high_pct = 50;
               3: high_pct = 80;
               default: high_pct = 100;
            endcase
            if (m == MODE_PINGPONG && high_pct < 80) high_pct = 90;
         end
         run_ticks(n, high_pct);
         random_ticks += n;
         phase++;
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (scoreboard.pending_frames.size() != 0) begin
         scoreboard.errors++;
         $display("%0d ns: %0d expected results never arrived", $time,
                  scoreboard.pending_frames.size());
      end
      $display("Sent %0d ticks and checked %0d results over %0d register writes,",
               ticks_sent, scoreboard.results_seen, writes_done);
      $display("covering all four modes, zero and saturated counts and periods, and stalls.");
      if (scoreboard.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

### files.f
sv/afs_pkg.sv
sv/afs_csr.sv
sv/afs_step.sv
sv/animation_frame_sequencer.sv
verif/testbench.sv
